/* sv/hhs_pkg.sv */
`default_nettype none

package hhs_pkg;

  // Width of every position and limit value.
  localparam int POS_W = 32;

  // Input tdata: two levels, two positions, recenter flag, two known positions,
  // two axis flags and the corner side, padded up to whole bytes.
  localparam int IN_BITS    = 6 + 4 * POS_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_TDATA_W - IN_BITS;

  // Output tdata: phase, three flags, limits valid and six limit values.
  localparam int OUT_BITS    = 7 + 6 * POS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  typedef enum logic [1:0] {
    OP_POLL         = 2'd0,
    OP_FULL_START   = 2'd1,
    OP_CORNER_START = 2'd2,
    OP_AXIS_START   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_Y_BOT    = 3'd1,
    PH_X_BOT    = 3'd2,
    PH_Y_TOP    = 3'd3,
    PH_X_TOP    = 3'd4,
    PH_RECENTER = 3'd5
  } phase_t;

  typedef logic signed [POS_W-1:0] pos_t;

  // Input item, lowest field last.
  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic                known_is_bottom;
    logic                has_x;
    logic                has_y;
    pos_t                known_x;
    pos_t                known_y;
    logic                recenter_active;
    pos_t                x_position;
    pos_t                y_position;
    logic                hall_x_level;
    logic                hall_y_level;
  } in_item_t;

  typedef struct packed {
    pos_t x_center;
    pos_t y_center;
    pos_t x_high_limit;
    pos_t x_low_limit;
    pos_t y_high_limit;
    pos_t y_low_limit;
  } limits_t;

  // Result item, lowest field last.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    limits_t              limits;
    logic                 limits_valid;
    logic                 recenter_request;
    logic                 abort_motion;
    logic                 refused;
    phase_t               phase;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/hhs_limits.sv */
`default_nettype none

module hhs_limits (
  input  var hhs_pkg::pos_t    y_bottom,
  input  var hhs_pkg::pos_t    x_bottom,
  input  var hhs_pkg::pos_t    y_top,
  input  var hhs_pkg::pos_t    x_top,
  output hhs_pkg::limits_t     limits
);
  import hhs_pkg::*;

  pos_t               y_lo, y_hi, x_lo, x_hi;
  logic [POS_W:0]     y_sum, x_sum;
  logic [POS_W:0]     y_adj, x_adj;

  // Order each axis pair into minimum and maximum.
  always_comb begin
    if (y_bottom < y_top) begin
      y_lo = y_bottom;
      y_hi = y_top;
    end else begin
      y_lo = y_top;
      y_hi = y_bottom;
    end
    if (x_bottom < x_top) begin
      x_lo = x_bottom;
      x_hi = x_top;
    end else begin
      x_lo = x_top;
      x_hi = x_bottom;
    end
  end

  // Sums are one bit wider so they cannot overflow. Adding the sign bit before
  // the halving shift makes the result truncate toward zero.
  assign y_sum = {y_lo[POS_W-1], y_lo} + {y_hi[POS_W-1], y_hi};
  assign x_sum = {x_lo[POS_W-1], x_lo} + {x_hi[POS_W-1], x_hi};
  assign y_adj = y_sum + {{POS_W{1'b0}}, y_sum[POS_W]};
  assign x_adj = x_sum + {{POS_W{1'b0}}, x_sum[POS_W]};

  assign limits.y_low_limit  = y_lo;
  assign limits.y_high_limit = y_hi;
  assign limits.x_low_limit  = x_lo;
  assign limits.x_high_limit = x_hi;
  assign limits.y_center     = pos_t'(y_adj[POS_W:1]);
  assign limits.x_center     = pos_t'(x_adj[POS_W:1]);

endmodule

`default_nettype wire

/* sv/two_axis_hall_homing_sequencer.sv */
// Homing sequencer for a two-axis gantry with active-low Hall sensors.
// Input items arrive on the s_ stream: s_tuser carries the operation (poll
// sample, full start, known-corner start, known-axis start) and s_tdata the
// sensor levels, positions and known-start data. Every input item yields
// exactly one result on the m_ stream with the phase, the refused, abort and
// recenter pulses, the limits-valid flag and the six limit registers.
// An item is held in an input register, its state update and limit computation
// run in one pass of logic, and the result is loaded into an output register
// that drives m_tvalid and m_tdata.
// Throughput is one item per cycle while m_tready stays high; the edge detection
// and phase update close through the state registers, so items may follow one
// another back to back.
// When m_tready is low the output register holds its result and the input
// register still takes one more item; s_tready drops only once both are full.
// Reset (rst, synchronous) clears the phase to idle, the previous sensor levels
// to not detected, the corner and limit registers to zero and limits-valid.
`default_nettype none

module two_axis_hall_homing_sequencer (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: hall_y_level, hall_x_level, y_position, x_position,
  // recenter_active, known_y, known_x, has_y, has_x, known_is_bottom, zero pad.
  input  wire  [hhs_pkg::IN_TDATA_W-1:0]    s_tdata,
  // Fields from bit 0: op.
  input  wire  [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // Fields from bit 0: phase, refused, abort_motion, recenter_request,
  // limits_valid, y_low_limit, y_high_limit, x_low_limit, x_high_limit,
  // y_center, x_center, zero pad.
  output logic [hhs_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import hhs_pkg::*;

  localparam int CORNER_Y_BOT = 0;
  localparam int CORNER_X_BOT = 1;
  localparam int CORNER_Y_TOP = 2;
  localparam int CORNER_X_TOP = 3;

  // Input stage.
  logic      in_valid;
  in_item_t  in_item;
  op_t       in_op;

  // Output stage.
  logic      out_valid;
  out_item_t out_item;

  // Sequencer state.
  phase_t    phase, phase_next;
  logic      prev_y, prev_y_next;
  logic      prev_x, prev_x_next;
  pos_t      corner [4];
  pos_t      corner_next [4];
  limits_t   limits;
  logic      limits_done;

  // Per-item results.
  logic      refused, abort_motion, recenter_request, do_limits;
  pos_t      y_top_eff;
  limits_t   limits_new;
  logic      advance;

  // The input stage moves on whenever the output register is free or drains.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_item;

  // Limit computation sees the top Y taken from this very sample when the Y
  // edge and the X sensor arrive together.
  assign y_top_eff = (phase == PH_Y_TOP) ? in_item.y_position : corner[CORNER_Y_TOP];

  hhs_limits u_limits (
    .y_bottom (corner[CORNER_Y_BOT]),
    .x_bottom (corner[CORNER_X_BOT]),
    .y_top    (y_top_eff),
    .x_top    (in_item.x_position),
    .limits   (limits_new)
  );

  // Next-state logic for one item.
  always_comb begin
    logic px;
    phase_next       = phase;
    prev_y_next      = prev_y;
    prev_x_next      = prev_x;
    corner_next      = corner;
    refused          = 1'b0;
    abort_motion     = 1'b0;
    recenter_request = 1'b0;
    do_limits        = 1'b0;
    px               = prev_x;
    case (in_op)
      OP_POLL: begin
        // Y edge, checked against the phase at poll entry.
        if (in_item.hall_y_level != prev_y) begin
          prev_y_next = in_item.hall_y_level;
          if (prev_y && !in_item.hall_y_level && phase == PH_Y_BOT) begin
            corner_next[CORNER_Y_BOT] = in_item.y_position;
            phase_next = PH_X_BOT;
          end else if (prev_y && !in_item.hall_y_level && phase == PH_Y_TOP) begin
            corner_next[CORNER_Y_TOP] = in_item.y_position;
            if (!in_item.hall_x_level) begin
              corner_next[CORNER_X_TOP] = in_item.x_position;
              do_limits        = 1'b1;
              recenter_request = 1'b1;
              phase_next       = PH_RECENTER;
              prev_x_next      = 1'b0;
              px               = 1'b0;
            end else begin
              phase_next = PH_X_TOP;
            end
          end else if (!prev_y && in_item.hall_y_level && phase == PH_X_BOT) begin
            phase_next = PH_Y_BOT;
          end else if (!prev_y && in_item.hall_y_level && phase == PH_X_TOP) begin
            phase_next = PH_Y_TOP;
          end
        end
        // X edge, same entry phase.
        if (in_item.hall_x_level != px) begin
          prev_x_next = in_item.hall_x_level;
          if (px && !in_item.hall_x_level && phase == PH_X_BOT) begin
            corner_next[CORNER_X_BOT] = in_item.x_position;
            phase_next = PH_Y_TOP;
          end else if (px && !in_item.hall_x_level && phase == PH_X_TOP) begin
            corner_next[CORNER_X_TOP] = in_item.x_position;
            do_limits        = 1'b1;
            recenter_request = 1'b1;
            phase_next       = PH_RECENTER;
          end
        end
        if (phase == PH_RECENTER && !in_item.recenter_active) begin
          phase_next = PH_IDLE;
        end
      end
      OP_FULL_START, OP_CORNER_START, OP_AXIS_START: begin
        if (in_op == OP_CORNER_START ||
            (in_op == OP_AXIS_START && in_item.has_y && in_item.has_x)) begin
          // Known corner: both sensors are taken as sitting on their magnets.
          abort_motion = 1'b1;
          prev_y_next  = 1'b0;
          prev_x_next  = 1'b0;
          for (int i = 0; i < 4; i++) corner_next[i] = '0;
          if (in_item.known_is_bottom) begin
            corner_next[CORNER_Y_BOT] = in_item.known_y;
            corner_next[CORNER_X_BOT] = in_item.known_x;
            phase_next = PH_Y_TOP;
          end else begin
            corner_next[CORNER_Y_TOP] = in_item.known_y;
            corner_next[CORNER_X_TOP] = in_item.known_x;
            phase_next = PH_Y_BOT;
          end
        end else if (in_op == OP_FULL_START || (!in_item.has_y && !in_item.has_x)) begin
          // Full start is refused while either sensor reads detected.
          if (!in_item.hall_y_level || !in_item.hall_x_level) begin
            refused    = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            abort_motion = 1'b1;
            for (int i = 0; i < 4; i++) corner_next[i] = '0;
            phase_next = PH_Y_BOT;
          end
        end else begin
          // Single known axis.
          abort_motion = 1'b1;
          prev_y_next  = in_item.hall_y_level;
          prev_x_next  = in_item.hall_x_level;
          for (int i = 0; i < 4; i++) corner_next[i] = '0;
          if (in_item.has_y) begin
            if (in_item.known_is_bottom) begin
              corner_next[CORNER_Y_BOT] = in_item.known_y;
              phase_next = PH_X_BOT;
            end else begin
              corner_next[CORNER_Y_TOP] = in_item.known_y;
              phase_next = PH_X_TOP;
            end
          end else begin
            if (in_item.known_is_bottom) begin
              corner_next[CORNER_X_BOT] = in_item.known_x;
              phase_next = PH_Y_BOT;
            end else begin
              corner_next[CORNER_X_TOP] = in_item.known_x;
              phase_next = PH_Y_TOP;
            end
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Handshake control of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= in_item_t'(s_tdata);
      in_op   <= op_t'(s_tuser);
    end
  end

  // Sequencer state commits as the item moves into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      prev_y      <= 1'b1;
      prev_x      <= 1'b1;
      limits_done <= 1'b0;
      limits      <= '0;
      for (int i = 0; i < 4; i++) corner[i] <= '0;
    end else if (advance) begin
      phase  <= phase_next;
      prev_y <= prev_y_next;
      prev_x <= prev_x_next;
      corner <= corner_next;
      if (do_limits) begin
        limits      <= limits_new;
        limits_done <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.pad              <= '0;
      out_item.phase            <= phase_next;
      out_item.refused          <= refused;
      out_item.abort_motion     <= abort_motion;
      out_item.recenter_request <= recenter_request;
      out_item.limits_valid     <= limits_done || do_limits;
      out_item.limits           <= do_limits ? limits_new : limits;
    end
  end

endmodule

`default_nettype wire
